// ===== src/stsgd_pkg.sv =====
// Shared constants, stream layout and helpers for the stress SGD term update block.
// Depends on nothing; used by stress_sgd_term_update, stsgd_checker and the testbench.
package stsgd_pkg;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_TERM  = 2'd2;

    // Stream widths.
    localparam int IN_DATA_W  = 184;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;

    // Fixed-point constants.
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [31:0] STEP_RESET = 32'h0001_0000;

    // Serial unit widths.
    localparam int MUL_W = 34;

    typedef logic [31:0] coord_t;
    typedef logic [MUL_W-1:0] opnd_t;

    // Saturate a 35-bit signed sum to the 32-bit position range.
    function automatic coord_t sat35(input logic signed [34:0] v);
        coord_t r;
        if (v > 35'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -35'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Apply a signed move of magnitude m to a position.
    function automatic coord_t move_pos(input coord_t pos, input opnd_t m,
                                        input logic subtract);
        logic signed [34:0] p;
        logic signed [34:0] d;
        p = {{3{pos[31]}}, pos};
        d = {1'b0, m};
        return subtract ? sat35(p - d) : sat35(p + d);
    endfunction

endpackage

// ===== src/stress_sgd_term_update.sv =====
// Top level of the stress SGD term update block: position store, bit-serial
// multiplier, square root and divider, and the sequencer. Uses stsgd_pkg.
//
// Write request: the result is issued from S_FIN; a read request passes S_RDA and S_RDOUT first.
// Term request: ten serial multiplications, a 33-step square root and two serial divisions,
// one bit per step; for coincident nodes the term stops after the square root.
// One request is in work at a time and the next is accepted the cycle after the result
// is issued; a waiting result does not block a new request.
// Reset clears control state and sets step_size to 1.0; the store is not cleared.
module stress_sgd_term_update #(
    parameter int NODES = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [31:0]                      cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // node_a, node_b, x_value, y_value, target_distance, weight_a, weight_b
    input  logic [stsgd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [stsgd_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // x_out, y_out
    output logic [stsgd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic                             m_axis_tuser
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [16:0] NODES_L = 17'(NODES);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDA   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_MLOAD = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_POST  = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_MAG   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DIVD  = 4'd10;
    localparam logic [3:0] S_WRA   = 4'd11;
    localparam logic [3:0] S_WRB   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;
    localparam logic [3:0] S_RDOUT = 4'd14;

    // Multiplication phases of a term.
    localparam logic [3:0] P_SQX = 4'd0;
    localparam logic [3:0] P_SQY = 4'd1;
    localparam logic [3:0] P_MUA = 4'd2;
    localparam logic [3:0] P_MUB = 4'd3;
    localparam logic [3:0] P_NX  = 4'd4;
    localparam logic [3:0] P_NY  = 4'd5;
    localparam logic [3:0] P_MAX = 4'd6;
    localparam logic [3:0] P_MAY = 4'd7;
    localparam logic [3:0] P_MBX = 4'd8;
    localparam logic [3:0] P_MBY = 4'd9;

    logic [3:0]  state_reg;
    logic [3:0]  ph_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] step_reg;

    // Request fields.
    logic [1:0]  func_reg;
    logic [9:0]  na_reg;
    logic [9:0]  nb_reg;
    logic [31:0] d_reg;
    logic [31:0] wa_reg;
    logic [31:0] wb_reg;

    // Positions and differences.
    stsgd_pkg::coord_t xa_reg, ya_reg, xb_reg, yb_reg;
    logic [32:0] dxa_reg, dya_reg;
    logic        dxneg_reg, dyneg_reg;

    // Serial arithmetic.
    stsgd_pkg::opnd_t mula_reg;
    logic [67:0] prod_reg;
    logic [65:0] sq_reg;
    logic [65:0] rad_reg;
    logic [35:0] rem_reg;
    logic [32:0] root_reg;
    logic [32:0] mag_reg;
    logic [33:0] dabs_reg;
    logic        dneg_reg;
    logic [30:0] mua_reg, mub_reg;
    logic [65:0] num_reg;
    logic [34:0] drem_reg;
    stsgd_pkg::opnd_t rx_reg, ry_reg;
    stsgd_pkg::opnd_t mvax_reg, mvay_reg, mvbx_reg, mvby_reg;

    // Results.
    stsgd_pkg::coord_t resx_reg, resy_reg;
    logic        resst_reg;
    logic        mvalid_reg;
    logic [63:0] mdata_reg;
    logic        muser_reg;

    // Position store, {y, x} per node.
    logic [63:0] pos_mem [NODES];
    logic [63:0] rdata_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [63:0] mem_wdata;

    // Input field views.
    logic [9:0]  in_na, in_nb;
    logic [16:0] in_na_ext, na_ext, nb_ext;
    logic        accept;
    logic        na_ok, nb_ok;
    logic [AW-1:0] addr_a, addr_b;

    assign in_na     = s_axis_tdata[9:0];
    assign in_nb     = s_axis_tdata[19:10];
    assign in_na_ext = {7'd0, in_na};
    assign na_ext    = {7'd0, na_reg};
    assign nb_ext    = {7'd0, nb_reg};
    assign na_ok     = na_ext < NODES_L;
    assign nb_ok     = nb_ext < NODES_L;
    assign addr_a    = na_ext[AW-1:0];
    assign addr_b    = nb_ext[AW-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;

    // Multiplier step: add the multiplicand when the low bit is set, then shift.
    logic [34:0] mul_sum;
    assign mul_sum = {1'b0, prod_reg[67:34]} + (prod_reg[0] ? {1'b0, mula_reg} : 35'd0);

    // Square root step on the next bit pair.
    logic [35:0] sq_rem;
    logic [35:0] sq_trial;
    logic        sq_take;
    assign sq_rem   = {rem_reg[33:0], rad_reg[65:64]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_take  = sq_rem >= sq_trial;

    // Divider step against twice the magnitude.
    logic [34:0] dv_rem;
    logic [34:0] dv_den;
    logic        dv_take;
    assign dv_rem  = {drem_reg[33:0], num_reg[65]};
    assign dv_den  = {1'b0, mag_reg, 1'b0};
    assign dv_take = dv_rem >= dv_den;

    // Step factor capped at 1.0 from the finished product.
    logic [47:0] mu_raw;
    logic [30:0] mu_cap;
    assign mu_raw = prod_reg[63:16];
    assign mu_cap = (mu_raw > {17'd0, stsgd_pkg::ONE_Q30}) ? stsgd_pkg::ONE_Q30
                                                           : mu_raw[30:0];

    // Differences of the two fetched positions and their magnitudes.
    logic signed [32:0] dx_s, dy_s;
    logic [32:0] dx_abs, dy_abs;
    assign dx_s   = $signed({xa_reg[31], xa_reg}) - $signed({xb_reg[31], xb_reg});
    assign dy_s   = $signed({ya_reg[31], ya_reg}) - $signed({yb_reg[31], yb_reg});
    assign dx_abs = dx_s[32] ? 33'(-dx_s) : 33'(dx_s);
    assign dy_abs = dy_s[32] ? 33'(-dy_s) : 33'(dy_s);

    // Signed distance error.
    logic signed [34:0] diff_s;
    assign diff_s = $signed({2'b00, mag_reg}) - $signed({3'b000, d_reg});

    // Moved positions; node a moves against the scaled difference, node b with it.
    logic negx, negy;
    stsgd_pkg::coord_t nax, nay, nbx, nby;
    assign negx = dneg_reg ^ dxneg_reg;
    assign negy = dneg_reg ^ dyneg_reg;
    assign nax  = stsgd_pkg::move_pos(xa_reg, mvax_reg, !negx);
    assign nay  = stsgd_pkg::move_pos(ya_reg, mvay_reg, !negy);
    assign nbx  = stsgd_pkg::move_pos(xb_reg, mvbx_reg, negx);
    assign nby  = stsgd_pkg::move_pos(yb_reg, mvby_reg, negy);

    // Store port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_a;
        mem_wdata = {nay, nax};
        if (accept && s_axis_tuser == stsgd_pkg::FUNC_WRITE && in_na_ext < NODES_L)
        begin
            mem_we    = 1'b1;
            mem_waddr = in_na_ext[AW-1:0];
            mem_wdata = s_axis_tdata[83:20];
        end
        else if (state_reg == S_WRA)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_WRB)
        begin
            mem_we    = 1'b1;
            mem_waddr = addr_b;
            mem_wdata = {nby, nbx};
        end
        mem_raddr = (state_reg == S_RDB) ? addr_b : addr_a;
    end

    // Position store with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= pos_mem[mem_raddr];
    end

    // Multiplier operands for each phase.
    stsgd_pkg::opnd_t op_a, op_b;
    always_comb
    begin
        case (ph_reg)
            P_SQX:   begin op_a = {1'b0, dxa_reg};   op_b = {1'b0, dxa_reg}; end
            P_SQY:   begin op_a = {1'b0, dya_reg};   op_b = {1'b0, dya_reg}; end
            P_MUA:   begin op_a = {2'b00, wa_reg};   op_b = {2'b00, step_reg}; end
            P_MUB:   begin op_a = {2'b00, wb_reg};   op_b = {2'b00, step_reg}; end
            P_NX:    begin op_a = dabs_reg;          op_b = {1'b0, dxa_reg}; end
            P_NY:    begin op_a = dabs_reg;          op_b = {1'b0, dya_reg}; end
            P_MAX:   begin op_a = {3'b000, mua_reg}; op_b = rx_reg; end
            P_MAY:   begin op_a = {3'b000, mua_reg}; op_b = ry_reg; end
            P_MBX:   begin op_a = {3'b000, mub_reg}; op_b = rx_reg; end
            default: begin op_a = {3'b000, mub_reg}; op_b = ry_reg; end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= stsgd_pkg::STEP_RESET;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            // The result is valid from its issue until it is taken.
            if (state_reg == S_FIN && (!mvalid_reg || m_axis_tready))
            begin
                mvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (s_axis_tuser)
                            stsgd_pkg::FUNC_READ: state_reg <= S_RDA;
                            stsgd_pkg::FUNC_TERM: state_reg <= S_RDA;
                            default:              state_reg <= S_FIN;
                        endcase
                    end
                end
                S_RDA:
                begin
                    if (func_reg == stsgd_pkg::FUNC_READ)
                        state_reg <= na_ok ? S_RDOUT : S_FIN;
                    else
                        state_reg <= (na_ok && nb_ok) ? S_RDB : S_FIN;
                end
                S_RDOUT: state_reg <= S_FIN;
                S_RDB:   state_reg <= S_DIFF;
                S_DIFF:  state_reg <= S_MLOAD;
                S_MLOAD: state_reg <= S_MUL;
                S_MUL:
                begin
                    if (cnt_reg == 7'(stsgd_pkg::MUL_W - 1))
                        state_reg <= S_POST;
                end
                S_POST:
                begin
                    case (ph_reg) inside
                        P_SQY:       state_reg <= S_SQRT;
                        P_NX, P_NY:  state_reg <= S_DIV;
                        P_MBY:       state_reg <= S_WRA;
                        default:     state_reg <= S_MLOAD;
                    endcase
                end
                S_SQRT:
                begin
                    if (cnt_reg == 7'd32)
                        state_reg <= S_MAG;
                end
                S_MAG:   state_reg <= (mag_reg == 33'd0) ? S_FIN : S_MLOAD;
                S_DIV:
                begin
                    if (cnt_reg == 7'd65)
                        state_reg <= S_DIVD;
                end
                S_DIVD:  state_reg <= S_MLOAD;
                S_WRA:   state_reg <= S_WRB;
                S_WRB:   state_reg <= S_FIN;
                S_FIN:
                begin
                    if (!mvalid_reg || m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                func_reg  <= s_axis_tuser;
                na_reg    <= in_na;
                nb_reg    <= in_nb;
                d_reg     <= s_axis_tdata[115:84];
                wa_reg    <= s_axis_tdata[147:116];
                wb_reg    <= s_axis_tdata[179:148];
                resx_reg  <= '0;
                resy_reg  <= '0;
                resst_reg <= 1'b0;
                ph_reg    <= P_SQX;
            end
            S_RDOUT:
            begin
                resx_reg <= rdata_reg[31:0];
                resy_reg <= rdata_reg[63:32];
            end
            S_RDB:
            begin
                xa_reg <= rdata_reg[31:0];
                ya_reg <= rdata_reg[63:32];
            end
            S_DIFF:
            begin
                xb_reg <= rdata_reg[31:0];
                yb_reg <= rdata_reg[63:32];
            end
            S_MLOAD:
            begin
                if (ph_reg == P_SQX)
                begin
                    // First square takes the fresh x difference directly.
                    dxneg_reg <= dx_s[32];
                    dyneg_reg <= dy_s[32];
                    dxa_reg   <= dx_abs;
                    dya_reg   <= dy_abs;
                    mula_reg  <= {1'b0, dx_abs};
                    prod_reg  <= {35'd0, dx_abs};
                end
                else
                begin
                    mula_reg <= op_a;
                    prod_reg <= {34'd0, op_b};
                end
                cnt_reg <= '0;
            end
            S_MUL:
            begin
                prod_reg <= {mul_sum, prod_reg[33:1]};
                cnt_reg  <= cnt_reg + 7'd1;
            end
            S_POST:
            begin
                cnt_reg  <= '0;
                rem_reg  <= '0;
                root_reg <= '0;
                drem_reg <= '0;
                case (ph_reg) inside
                    P_SQX: sq_reg  <= prod_reg[65:0];
                    P_SQY: rad_reg <= sq_reg + prod_reg[65:0];
                    P_MUA: mua_reg <= mu_cap;
                    P_MUB: mub_reg <= mu_cap;
                    P_NX, P_NY: num_reg <= prod_reg[65:0];
                    P_MAX: mvax_reg <= prod_reg[63:30];
                    P_MAY: mvay_reg <= prod_reg[63:30];
                    P_MBX: mvbx_reg <= prod_reg[63:30];
                    default: mvby_reg <= prod_reg[63:30];
                endcase
                if (ph_reg != P_NX && ph_reg != P_NY && ph_reg != P_SQY)
                    ph_reg <= ph_reg + 4'd1;
            end
            S_SQRT:
            begin
                rad_reg  <= {rad_reg[63:0], 2'b00};
                rem_reg  <= sq_take ? (sq_rem - sq_trial) : sq_rem;
                root_reg <= {root_reg[31:0], sq_take};
                cnt_reg  <= cnt_reg + 7'd1;
                mag_reg  <= {root_reg[31:0], sq_take};
            end
            S_MAG:
            begin
                resst_reg <= (mag_reg == 33'd0);
                dneg_reg  <= diff_s[34];
                dabs_reg  <= diff_s[34] ? 34'(-diff_s) : 34'(diff_s);
                ph_reg    <= P_MUA;
            end
            S_DIV:
            begin
                drem_reg <= dv_take ? (dv_rem - dv_den) : dv_rem;
                num_reg  <= {num_reg[64:0], dv_take};
                cnt_reg  <= cnt_reg + 7'd1;
            end
            S_DIVD:
            begin
                if (ph_reg == P_NX)
                    rx_reg <= num_reg[33:0];
                else
                    ry_reg <= num_reg[33:0];
                ph_reg <= ph_reg + 4'd1;
            end
            S_FIN:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    mdata_reg <= {resy_reg, resx_reg};
                    muser_reg <= resst_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sim/stsgd_checker.sv =====
// Checker for the stress SGD term update block: watches the request, result and
// register write ports, predicts each result and compares. Uses stsgd_pkg.
module stsgd_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [31:0]                      cfg_wdata,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [stsgd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [stsgd_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [stsgd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                             m_axis_tuser,
    output int                               fail_count,
    output int                               pending,
    output int                               checked,
    output int                               skipped
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        status;
    } position_result_t;

    localparam int NODE_COUNT = 1024;

    logic [31:0] pos_x [NODE_COUNT];
    logic [31:0] pos_y [NODE_COUNT];
    logic [31:0] learn_rate;
    position_result_t expected_results[$];

    // Floor square root of a value below 2^66, two bits per step.
    function automatic logic [33:0] floor_sqrt(input logic [65:0] v);
        logic [71:0] rem;
        logic [35:0] root;
        logic [71:0] trial;
        rem  = '0;
        root = '0;
        for (int k = 32; k >= 0; k--)
        begin
            rem   = (rem << 2) | 72'(v[2*k +: 2]);
            trial = 72'((root << 2) | 36'd1);
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 36'd1;
            end
            else
                root = root << 1;
        end
        return root[33:0];
    endfunction

    // Step factor: weight times learning rate, capped at 1.0 in Q2.30.
    function automatic logic [63:0] capped_rate(input logic [31:0] w);
        logic [63:0] p;
        p = (64'(w) * 64'(learn_rate)) >> 16;
        return (p > 64'h4000_0000) ? 64'h4000_0000 : p;
    endfunction

    // Signed displacement along one axis for one node.
    function automatic logic signed [71:0] axis_move(input logic [63:0] mu,
                                                     input logic signed [39:0] diff,
                                                     input logic signed [39:0] dv,
                                                     input logic [33:0] mag);
        logic [127:0] num;
        logic [127:0] r;
        logic [127:0] m;
        logic         neg;
        logic [39:0]  ad;
        logic [39:0]  av;
        neg = (diff < 0) != (dv < 0);
        ad  = diff < 0 ? -diff : diff;
        av  = dv < 0 ? -dv : dv;
        num = 128'(ad) * 128'(av);
        r   = num / (128'(mag) << 1);
        m   = (128'(mu) * r) >> 30;
        return neg ? -$signed(72'(m)) : $signed(72'(m));
    endfunction

    function automatic logic [31:0] clamp_pos(input logic signed [71:0] v);
        if (v > 72'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        else if (v < -72'sh8000_0000)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Apply one term to the store copy; returns the coincident-node flag.
    function automatic logic apply_stress_term(input logic [9:0] a, input logic [9:0] b,
                                               input logic [31:0] target,
                                               input logic [31:0] wa,
                                               input logic [31:0] wb);
        logic signed [39:0] dx, dy, diff;
        logic [65:0]        sq;
        logic [33:0]        mag;
        logic [63:0]        mua, mub;
        logic [39:0]        adx, ady;
        logic signed [71:0] pa_x, pa_y, pb_x, pb_y;
        if (a >= NODE_COUNT || b >= NODE_COUNT)
            return 1'b0;
        dx  = 40'($signed(pos_x[a])) - 40'($signed(pos_x[b]));
        dy  = 40'($signed(pos_y[a])) - 40'($signed(pos_y[b]));
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        sq  = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
        mag = floor_sqrt(sq);
        if (mag == 0)
            return 1'b1;
        diff = $signed(40'(mag)) - $signed(40'(target));
        mua  = capped_rate(wa);
        mub  = capped_rate(wb);
        pa_x = 72'($signed(pos_x[a])) - axis_move(mua, diff, dx, mag);
        pa_y = 72'($signed(pos_y[a])) - axis_move(mua, diff, dy, mag);
        pb_x = 72'($signed(pos_x[b])) + axis_move(mub, diff, dx, mag);
        pb_y = 72'($signed(pos_y[b])) + axis_move(mub, diff, dy, mag);
        pos_x[a] = clamp_pos(pa_x);
        pos_y[a] = clamp_pos(pa_y);
        pos_x[b] = clamp_pos(pb_x);
        pos_y[b] = clamp_pos(pb_y);
        return 1'b0;
    endfunction

    initial
    begin
        fail_count = 0;
        checked    = 0;
        skipped    = 0;
        learn_rate = stsgd_pkg::STEP_RESET;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            pos_x[i] = '0;
            pos_y[i] = '0;
        end
    end

    assign pending = expected_results.size();

    // Sample at the falling edge: the handshake completes at the next rising edge.
    always @(negedge clk)
    begin
        position_result_t exp_r;
        position_result_t got_r;
        logic [9:0]       a;
        if (!rst_n)
            learn_rate = stsgd_pkg::STEP_RESET;
        else
        begin
            if (cfg_we)
                learn_rate = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                exp_r = '0;
                a     = s_axis_tdata[9:0];
                case (s_axis_tuser)
                    stsgd_pkg::FUNC_WRITE:
                    begin
                        pos_x[a] = s_axis_tdata[51:20];
                        pos_y[a] = s_axis_tdata[83:52];
                    end
                    stsgd_pkg::FUNC_READ:
                    begin
                        exp_r.x = pos_x[a];
                        exp_r.y = pos_y[a];
                    end
                    stsgd_pkg::FUNC_TERM:
                    begin
                        exp_r.status = apply_stress_term(a, s_axis_tdata[19:10],
                            s_axis_tdata[115:84], s_axis_tdata[147:116],
                            s_axis_tdata[179:148]);
                        if (exp_r.status)
                            skipped++;
                    end
                    default: ;
                endcase
                expected_results.insert(expected_results.size(), exp_r);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_r = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
                checked++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected: x=%h y=%h status=%b",
                             $time, got_r.x, got_r.y, got_r.status);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got_r.x !== exp_r.x)
                    begin
                        $display("%0t: x_out expected %h actual %h", $time, exp_r.x, got_r.x);
                        fail_count++;
                    end
                    if (got_r.y !== exp_r.y)
                    begin
                        $display("%0t: y_out expected %h actual %h", $time, exp_r.y, got_r.y);
                        fail_count++;
                    end
                    if (got_r.status !== exp_r.status)
                    begin
                        $display("%0t: status expected %b actual %b", $time,
                                 exp_r.status, got_r.status);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_stress_sgd_term_update.sv =====
// Testbench top for the stress SGD term update block: clock, reset, requests,
// register writes, result back-pressure and verdict. Uses stsgd_pkg and stsgd_checker.
module tb_stress_sgd_term_update;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam int PHASE_ITEMS = 120;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [31:0]                      cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [stsgd_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [stsgd_pkg::IN_USER_W-1:0]  s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [stsgd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;

    int fail_count;
    int pending;
    int checked;
    int skipped;
    int sent;
    int idle_cycles;
    int burst_left;
    logic in_taken;
    logic any_taken;
    logic [1023:0] written;
    logic [9:0]    written_nodes[$];
    logic [31:0]   last_x;
    logic [31:0]   last_y;

    stress_sgd_term_update DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    stsgd_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .pending(pending), .checked(checked),
        .skipped(skipped)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Handshake flags sampled mid-cycle, used at the following rising edge.
    always @(negedge clk)
    begin
        in_taken  <= s_axis_tvalid && s_axis_tready;
        any_taken <= (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if (!rst_n || any_taken)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result back-pressure: alternate between always-ready, random and heavy stall modes.
    initial
    begin
        int mode;
        int span;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Send one request and wait for its acceptance; gaps fall between bursts.
    task automatic send_request(input logic [1:0] fn, input logic [9:0] a,
                                input logic [9:0] b, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] target,
                                input logic [31:0] wa, input logic [31:0] wb);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {4'b0, wb, wa, target, y, x, b, a};
        @(posedge clk);
        while (!in_taken)
            @(posedge clk);
        sent++;
        if (fn == stsgd_pkg::FUNC_WRITE && !written[a])
        begin
            written[a] = 1'b1;
            written_nodes.insert(written_nodes.size(), a);
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 25);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Let every outstanding result drain, then write the learning rate.
    task automatic set_learn_rate(input logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [9:0] pick_written();
        return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h4000_0000);
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    // One random request; mostly writes and terms on a small node pool.
    task automatic random_request();
        int kind;
        logic [9:0] a;
        logic [9:0] b;
        logic [31:0] x;
        logic [31:0] y;
        kind = $urandom_range(0, 99);
        if (kind < 30 || written_nodes.size() < 2)
        begin
            a = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0)
            begin
                x = last_x;
                y = last_y;
            end
            else
            begin
                x = rand_coord();
                y = rand_coord();
            end
            last_x = x;
            last_y = y;
            send_request(stsgd_pkg::FUNC_WRITE, a, 10'($urandom), x, y, $urandom, $urandom,
                         $urandom);
        end
        else if (kind < 50)
            send_request(stsgd_pkg::FUNC_READ, pick_written(), 10'($urandom), $urandom,
                         $urandom, $urandom, $urandom, $urandom);
        else if (kind < 95)
        begin
            a = pick_written();
            b = ($urandom_range(0, 15) == 0) ? a : pick_written();
            send_request(stsgd_pkg::FUNC_TERM, a, b, $urandom, $urandom,
                         $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0040_0000),
                         rand_weight(), rand_weight());
        end
        else
            send_request(FUNC_UNUSED, 10'($urandom), 10'($urandom), $urandom, $urandom,
                         $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        logic [31:0] rates[5];
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = stsgd_pkg::FUNC_WRITE;
        written       = '0;
        sent          = 0;
        burst_left    = 0;
        last_x        = '0;
        last_y        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme nodes and coordinates, coincident nodes, saturation.
        set_learn_rate(stsgd_pkg::STEP_RESET);
        send_request(stsgd_pkg::FUNC_WRITE, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     0, 0, 0);
        send_request(stsgd_pkg::FUNC_WRITE, 10'd1023, 10'd1023, 32'h8000_0000,
                     32'h8000_0000, 0, 0, 0);
        send_request(stsgd_pkg::FUNC_WRITE, 10'd1, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     0, 0, 0);
        send_request(stsgd_pkg::FUNC_WRITE, 10'd2, 10'd0, 32'h0001_0000, 32'hFFFF_0000,
                     0, 0, 0);
        send_request(stsgd_pkg::FUNC_READ, 10'd0, 10'd0, 0, 0, 0, 0, 0);
        send_request(stsgd_pkg::FUNC_READ, 10'd1023, 10'd0, 0, 0, 0, 0, 0);
        send_request(stsgd_pkg::FUNC_TERM, 10'd2, 10'd2, 0, 0, 0, 0, 0);
        send_request(stsgd_pkg::FUNC_TERM, 10'd0, 10'd0, 0, 0, 32'h0001_0000,
                     32'hFFFF_FFFF, 0);
        send_request(stsgd_pkg::FUNC_TERM, 10'd0, 10'd1, 0, 0, 0, 32'h4000_0000,
                     32'h4000_0000);
        send_request(stsgd_pkg::FUNC_TERM, 10'd0, 10'd1023, 0, 0, 0, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
        send_request(stsgd_pkg::FUNC_TERM, 10'd0, 10'd1023, 0, 0, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(stsgd_pkg::FUNC_TERM, 10'd2, 10'd1, 0, 0, 32'h0002_0000,
                     32'h2000_0000, 0);
        send_request(FUNC_UNUSED, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(stsgd_pkg::FUNC_READ, 10'd0, 10'd0, 0, 0, 0, 0, 0);
        send_request(stsgd_pkg::FUNC_READ, 10'd1, 10'd0, 0, 0, 0, 0, 0);
        send_request(stsgd_pkg::FUNC_READ, 10'd2, 10'd0, 0, 0, 0, 0, 0);
        send_request(stsgd_pkg::FUNC_READ, 10'd1023, 10'd0, 0, 0, 0, 0, 0);

        // Random phases, each under a different learning rate.
        rates[0] = 32'h0000_0000;
        rates[1] = 32'hFFFF_FFFF;
        rates[2] = $urandom;
        rates[3] = 32'h0000_4000;
        rates[4] = stsgd_pkg::STEP_RESET;
        foreach (rates[p])
        begin
            set_learn_rate(rates[p]);
            repeat (PHASE_ITEMS) random_request();
        end

        // Drain and verdict.
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d requests under five learning rates; %0d results compared,",
                 sent, checked);
        $display("%0d terms skipped for coincident nodes.", skipped);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
